// ===== rtl/eavt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle and velocity tracker package
// Shared constants, state encoding and control and status structs.
// ----------------------------------------------------------------------------
package eavt_pkg;

  localparam int ANGLE_BITS_DEF = 14;
  localparam int TIME_W         = 32;
  localparam int RAW_W          = 16;
  localparam int VEL_W          = 34;
  localparam int MICRO_W        = 20;
  localparam int CFG_IDX_W      = 2;

  localparam logic [MICRO_W-1:0] MICRO            = 20'd1000000;
  localparam logic [TIME_W-1:0]  MAX_IVL_RESET    = 32'd500000;
  localparam logic [TIME_W-1:0]  DEFAULT_IVL_RESET = 32'd1000;
  localparam logic [63:0]        VEL_POS_LIMIT    = 64'd8589934591;
  localparam logic [63:0]        VEL_NEG_LIMIT    = 64'd8589934592;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INTERVAL = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic prep;
  } front_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/encoder_angle_velocity_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle and velocity tracker
// Results come from the bit-serial divider, which produces one of its
// ANGLE_BITS + 19 quotient bits per cycle. A new item is taken only once
// the previous result has been loaded into the output register, and it is
// taken while that result still waits there.
// Reset: synchronous; clears previous angle and time and restores registers.
// ----------------------------------------------------------------------------
module encoder_angle_velocity_tracker import eavt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int OUT_BITS  = 2 * ANGLE_BITS + TIME_W + VEL_W,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // raw_word[15:0], sample_time[47:16]
  input  logic [47:0]          s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // angle_out, angle_delta, interval_used, velocity, zero fill
  output logic [OUT_W-1:0]     m_axis_tdata,
  // interval_replaced
  output logic                 m_axis_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  localparam int NUM_W = ANGLE_BITS + 19;

  state_t state, state_next;
  front_ctrl_t front_ctrl;
  div_stat_t   div_stat;
  logic        div_start;
  logic        out_load;
  logic        out_free;

  logic [TIME_W-1:0]     max_interval_us;
  logic [TIME_W-1:0]     default_interval_us;
  logic [ANGLE_BITS-1:0] f_angle;
  logic [ANGLE_BITS-1:0] f_delta;
  logic [TIME_W-1:0]     f_interval;
  logic                  f_replaced;
  logic                  f_negative;
  logic [NUM_W-1:0]      f_dividend;
  logic [NUM_W-1:0]      quotient;
  logic [63:0]           q_ext;
  logic [63:0]           q_neg;
  logic [VEL_W-1:0]      vel_next;

  logic [ANGLE_BITS-1:0] out_angle;
  logic [ANGLE_BITS-1:0] out_delta;
  logic [TIME_W-1:0]     out_interval;
  logic [VEL_W-1:0]      out_velocity;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_interval_us     <= MAX_IVL_RESET;
      default_interval_us <= DEFAULT_IVL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_INTERVAL:     max_interval_us <= cfg_data;
        REG_DEFAULT_INTERVAL: default_interval_us <= cfg_data;
        default: ;
      endcase
    end
  end

  eavt_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .NUM_W      (NUM_W)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .ctrl                (front_ctrl),
    .raw_word            (s_axis_tdata[15:0]),
    .sample_time         (s_axis_tdata[47:16]),
    .max_interval_us     (max_interval_us),
    .default_interval_us (default_interval_us),
    .angle               (f_angle),
    .delta               (f_delta),
    .interval_used       (f_interval),
    .interval_replaced   (f_replaced),
    .negative            (f_negative),
    .dividend            (f_dividend)
  );

  eavt_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (f_dividend),
    .divisor  (f_interval),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_axis_tvalid) state_next = S_PREP;
      S_PREP:  state_next = S_START;
      S_START: state_next = S_WAIT;
      S_WAIT:  if (div_stat.done) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_free           = !m_axis_tvalid || m_axis_tready;
    s_axis_tready      = (state == S_IDLE) && !rst;
    front_ctrl.capture = s_axis_tready && s_axis_tvalid;
    front_ctrl.prep    = (state == S_PREP);
    div_start          = (state == S_START);
    out_load           = (state == S_DONE) && out_free;
  end

  always_comb begin
    q_ext = 64'(quotient);
    q_neg = ~q_ext + 64'd1;
    if (!f_negative) begin
      vel_next = (q_ext > VEL_POS_LIMIT) ? VEL_POS_LIMIT[VEL_W-1:0] : q_ext[VEL_W-1:0];
    end else begin
      vel_next = (q_ext > VEL_NEG_LIMIT) ? VEL_NEG_LIMIT[VEL_W-1:0] : q_neg[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_angle    <= f_angle;
      out_delta    <= f_delta;
      out_interval <= f_interval;
      out_velocity <= vel_next;
      m_axis_tuser <= f_replaced;
    end
  end

  assign m_axis_tdata = OUT_W'({out_velocity, out_interval, out_delta, out_angle});

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == S_WAIT))
    else $error("divider finished outside the wait state");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  a_interval_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_interval != '0))
    else $error("zero interval presented");

  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/eavt_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle and velocity tracker front end
// Captures a sample, forms angle, wrapped delta and interval, then selects
// the divisor and scales the delta magnitude for the divider.
// ----------------------------------------------------------------------------
module eavt_front import eavt_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int NUM_W      = ANGLE_BITS + 19
) (
  input  logic                  clk,
  input  logic                  rst,
  input  front_ctrl_t           ctrl,
  input  logic [RAW_W-1:0]      raw_word,
  input  logic [TIME_W-1:0]     sample_time,
  input  logic [TIME_W-1:0]     max_interval_us,
  input  logic [TIME_W-1:0]     default_interval_us,
  output logic [ANGLE_BITS-1:0] angle,
  output logic [ANGLE_BITS-1:0] delta,
  output logic [TIME_W-1:0]     interval_used,
  output logic                  interval_replaced,
  output logic                  negative,
  output logic [NUM_W-1:0]      dividend
);

  logic [ANGLE_BITS-1:0] angle_prev;
  logic [TIME_W-1:0]     prev_time;
  logic [TIME_W-1:0]     interval_raw;
  logic [ANGLE_BITS-1:0] angle_next;
  logic [ANGLE_BITS-1:0] delta_mag;
  logic                  replace;

  always_comb begin
    angle_next = raw_word[ANGLE_BITS-1:0];
    angle_next[ANGLE_BITS-1] = ~raw_word[ANGLE_BITS-1];
    delta_mag = delta[ANGLE_BITS-1] ? (~delta + 1'b1) : delta;
    replace = (interval_raw == '0) || (interval_raw > max_interval_us);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_prev <= '0;
      prev_time  <= '0;
    end else if (ctrl.capture) begin
      angle_prev <= angle_next;
      prev_time  <= sample_time;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      angle        <= angle_next;
      delta        <= angle_next - angle_prev;
      interval_raw <= sample_time - prev_time;
    end
    if (ctrl.prep) begin
      interval_replaced <= replace;
      if (!replace) begin
        interval_used <= interval_raw;
      end else if (default_interval_us == '0) begin
        interval_used <= TIME_W'(1);
      end else begin
        interval_used <= default_interval_us;
      end
      negative <= delta[ANGLE_BITS-1];
      dividend <= NUM_W'(delta_mag) * NUM_W'(MICRO);
    end
  end

endmodule

// ===== rtl/eavt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder angle and velocity tracker divider
// Restoring radix-2 divider, one quotient bit per cycle. The dividend shift
// register collects the quotient as the dividend bits move out.
// ----------------------------------------------------------------------------
module eavt_div import eavt_pkg::*; #(
  parameter int NUM_W = ANGLE_BITS_DEF + 19
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic [NUM_W-1:0]  quotient,
  output div_stat_t         stat
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [CNT_W-1:0]  cnt;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dsr;
  logic [TIME_W:0]   trial;
  logic [TIME_W:0]   diff;
  logic              fits;

  always_comb begin
    trial = {rem, quotient[NUM_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = ~diff[TIME_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(NUM_W - 1);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      dsr      <= divisor;
      rem      <= '0;
    end else if (stat.busy) begin
      quotient <= {quotient[NUM_W-2:0], fits};
      rem      <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
    end
  end

endmodule
